// ===== design/bqe_pkg.sv =====
`default_nettype none
package bqe_pkg;

    localparam int POS_W = 32;
    localparam int CAM_W = 16;
    localparam int SIZE_W = 24;
    localparam int UV_W = 16;
    localparam int EXT_W = 26;
    localparam int PROD_W = CAM_W + SIZE_W + 1;
    localparam int SUM_W = POS_W + 2;
    localparam int NUM_REGS = 6;
    localparam int REG_IDX_W = 3;
    localparam int NUM_VERTS = 6;
    localparam int VERT_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] SLOT_INVALID = 2'd3;

    // Bit k set means the corner of vertex k takes the plus sign.
    // The u corner follows the right sign and the v corner the up sign.
    localparam logic [NUM_VERTS-1:0] CORNER_R_POS = 6'b110010;
    localparam logic [NUM_VERTS-1:0] CORNER_U_POS = 6'b010011;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAM_RIGHT_X = 3'd0,
        REG_CAM_RIGHT_Y = 3'd1,
        REG_CAM_RIGHT_Z = 3'd2,
        REG_CAM_UP_X    = 3'd3,
        REG_CAM_UP_Y    = 3'd4,
        REG_CAM_UP_Z    = 3'd5
    } t_reg_idx;

    localparam logic [CAM_W-1:0] CAM_ONE = 16'h4000;

    typedef logic [EXT_W-1:0] t_ext;
    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        t_pos [2:0]      pos;
        t_ext [2:0]      hr;
        t_ext [2:0]      hu;
        logic [UV_W-1:0] u0;
        logic [UV_W-1:0] v0;
        logic [UV_W-1:0] u1;
        logic [UV_W-1:0] v1;
        logic [31:0]     color;
        logic [1:0]      slot;
    } t_bqe_job;

    typedef struct packed {
        t_pos [2:0]      pos;
        logic [UV_W-1:0] tex_u;
        logic [UV_W-1:0] tex_v;
        logic [1:0]      page_index;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
        logic            slot_error;
        logic            last;
    } t_bqe_vert;

endpackage
`default_nettype wire

// ===== design/bqe_front.sv =====
`default_nettype none
module bqe_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [2:0]                i_cfg_index,
    input  wire logic [15:0]               i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [31:0]               i_pos_x,
    input  wire logic [31:0]               i_pos_y,
    input  wire logic [31:0]               i_pos_z,
    input  wire logic [23:0]               i_size,
    input  wire logic [31:0]               i_color,
    input  wire logic [1:0]                i_slot,
    input  wire logic [15:0]               i_u0,
    input  wire logic [15:0]               i_v0,
    input  wire logic [15:0]               i_u1,
    input  wire logic [15:0]               i_v1,
    output logic                           o_push,
    input  wire logic                      i_push_ready,
    output bqe_pkg::t_bqe_job              o_job
);
    import bqe_pkg::*;

    logic [CAM_W-1:0]  r_cam [NUM_REGS];
    logic              r_valid;
    t_pos [2:0]        r_pos;
    logic [SIZE_W-1:0] r_size;
    logic [31:0]       r_color;
    logic [1:0]        r_slot;
    logic [UV_W-1:0]   r_u0, r_v0, r_u1, r_v1;
    logic              accept;
    logic signed [PROD_W-1:0] prod [NUM_REGS];
    logic signed [PROD_W-1:0] rnd  [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[REG_CAM_RIGHT_X] <= CAM_ONE;
            r_cam[REG_CAM_RIGHT_Y] <= '0;
            r_cam[REG_CAM_RIGHT_Z] <= '0;
            r_cam[REG_CAM_UP_X]    <= '0;
            r_cam[REG_CAM_UP_Y]    <= CAM_ONE;
            r_cam[REG_CAM_UP_Z]    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CAM_RIGHT_X: r_cam[REG_CAM_RIGHT_X] <= i_cfg_data;
                REG_CAM_RIGHT_Y: r_cam[REG_CAM_RIGHT_Y] <= i_cfg_data;
                REG_CAM_RIGHT_Z: r_cam[REG_CAM_RIGHT_Z] <= i_cfg_data;
                REG_CAM_UP_X:    r_cam[REG_CAM_UP_X]    <= i_cfg_data;
                REG_CAM_UP_Y:    r_cam[REG_CAM_UP_Y]    <= i_cfg_data;
                REG_CAM_UP_Z:    r_cam[REG_CAM_UP_Z]    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_size   <= i_size;
            r_color  <= i_color;
            r_slot   <= i_slot;
            r_u0     <= i_u0;
            r_v0     <= i_v0;
            r_u1     <= i_u1;
            r_v1     <= i_v1;
        end
    end

    // Half extent is the product rounded to nearest, ties upward, scaled by 2^-15.
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            prod[i] = $signed(r_cam[i]) * $signed({1'b0, r_size});
            rnd[i]  = prod[i] + PROD_W'(16384);
        end
    end

    always_comb begin
        o_job.pos   = r_pos;
        o_job.color = r_color;
        o_job.slot  = r_slot;
        o_job.u0    = r_u0;
        o_job.v0    = r_v0;
        o_job.u1    = r_u1;
        o_job.v1    = r_v1;
        for (int a = 0; a < 3; a++) begin
            o_job.hr[a] = rnd[a][PROD_W-1:PROD_W-EXT_W];
            o_job.hu[a] = rnd[a+3][PROD_W-1:PROD_W-EXT_W];
        end
    end

endmodule
`default_nettype wire

// ===== design/bqe_queue.sv =====
`default_nettype none
module bqe_queue #(
    parameter int DEPTH = bqe_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_ready,
    input  wire bqe_pkg::t_bqe_job i_data,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output bqe_pkg::t_bqe_job      o_data
);
    import bqe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bqe_job         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/bqe_back.sv =====
`default_nettype none
module bqe_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  wire bqe_pkg::t_bqe_job i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bqe_pkg::t_bqe_vert     o_vert
);
    import bqe_pkg::*;

    logic [VERT_IDX_W-1:0]   r_k;
    logic                    r_valid;
    t_bqe_vert               r_vert;
    t_bqe_vert               n_vert;
    logic                    load, is_err, is_last, r_pos_sign, u_pos_sign;
    logic signed [SUM_W-1:0] sum [3];

    assign load       = i_job_valid && (!r_valid || i_ready);
    assign is_err     = i_job.slot == SLOT_INVALID;
    assign is_last    = is_err || (r_k == VERT_IDX_W'(NUM_VERTS - 1));
    assign o_pop      = load && is_last;
    assign r_pos_sign = CORNER_R_POS[r_k];
    assign u_pos_sign = CORNER_U_POS[r_k];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum[a] = SUM_W'($signed(i_job.pos[a]))
                   + (r_pos_sign ? SUM_W'($signed(i_job.hr[a]))
                                 : -SUM_W'($signed(i_job.hr[a])))
                   + (u_pos_sign ? SUM_W'($signed(i_job.hu[a]))
                                 : -SUM_W'($signed(i_job.hu[a])));
        end
    end

    always_comb begin
        n_vert = '0;
        n_vert.last = is_last;
        if (is_err) begin
            n_vert.slot_error = 1'b1;
        end else begin
            for (int a = 0; a < 3; a++) begin
                if (sum[a] > SUM_W'(32'sh7fffffff)) begin
                    n_vert.pos[a] = 32'h7fffffff;
                end else if (sum[a] < -SUM_W'(64'sh80000000)) begin
                    n_vert.pos[a] = 32'h80000000;
                end else begin
                    n_vert.pos[a] = sum[a][POS_W-1:0];
                end
            end
            n_vert.tex_u      = r_pos_sign ? i_job.u1 : i_job.u0;
            n_vert.tex_v      = u_pos_sign ? i_job.v1 : i_job.v0;
            n_vert.page_index = i_job.slot;
            n_vert.red        = i_job.color[23:16];
            n_vert.green      = i_job.color[15:8];
            n_vert.blue       = i_job.color[7:0];
            n_vert.alpha      = i_job.color[31:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= is_last ? '0 : r_k + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vert <= n_vert;
        end
    end

    assign o_valid = r_valid;
    assign o_vert  = r_vert;

endmodule
`default_nettype wire

// ===== design/billboard_quad_expander.sv =====
`default_nettype none
// Expands one camera-facing billboard into six triangle vertices.
// The input channel takes one billboard word per handshake: center, edge length,
// packed color, texture page slot and two texture corners. The output channel
// gives one vertex word per handshake, with last set on the final vertex of a
// billboard. A billboard with the invalid slot gives a single word with
// slot_error and last set and all other fields zero.
// The configuration channel writes the camera right and up vectors; it is always
// ready, and writes to indexes beyond the six registers are dropped.
// The first vertex passes the input register, a job queue entry and the output
// register. The output register gives one vertex per cycle while the receiver
// is ready, so six vertices per billboard set the sustained rate; the input
// register and the four-entry job queue keep taking billboards while it works.
// When the receiver stalls, the output word holds and the queue fills; the
// input channel then drops ready until a queue entry frees.
// Reset is synchronous and active low; it empties the pipeline and restores
// the vectors to right (1,0,0) and up (0,1,0).
module billboard_quad_expander #(
    parameter int QUEUE_DEPTH = bqe_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [23:0] i_size,
    input  wire logic [31:0] i_color,
    input  wire logic [1:0]  i_textpage_slot,
    input  wire logic [15:0] i_u0,
    input  wire logic [15:0] i_v0,
    input  wire logic [15:0] i_u1,
    input  wire logic [15:0] i_v1,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_vx,
    output logic [31:0]      o_vy,
    output logic [31:0]      o_vz,
    output logic [15:0]      o_tex_u,
    output logic [15:0]      o_tex_v,
    output logic [1:0]       o_page_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_slot_error,
    output logic             o_last
);
    import bqe_pkg::*;

    logic      push, push_ready, job_valid, pop;
    t_bqe_job  front_job, head_job;
    t_bqe_vert vert;

    assign o_cfg_ready = 1'b1;

    bqe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_size       (i_size),
        .i_color      (i_color),
        .i_slot       (i_textpage_slot),
        .i_u0         (i_u0),
        .i_v0         (i_v0),
        .i_u1         (i_u1),
        .i_v1         (i_v1),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_job        (front_job)
    );

    bqe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (push_ready),
        .i_data  (front_job),
        .o_valid (job_valid),
        .i_pop   (pop),
        .o_data  (head_job)
    );

    bqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_vert      (vert)
    );

    assign o_vx         = vert.pos[0];
    assign o_vy         = vert.pos[1];
    assign o_vz         = vert.pos[2];
    assign o_tex_u      = vert.tex_u;
    assign o_tex_v      = vert.tex_v;
    assign o_page_index = vert.page_index;
    assign o_red        = vert.red;
    assign o_green      = vert.green;
    assign o_blue       = vert.blue;
    assign o_alpha      = vert.alpha;
    assign o_slot_error = vert.slot_error;
    assign o_last       = vert.last;

endmodule
`default_nettype wire
